// ----- design/sfe_pkg.sv -----
`timescale 1ns / 1ps

package sfe_pkg;

  // Nesting level is taken modulo this depth
  localparam int MAX_NESTING = 32;
  localparam int LVL_W       = (MAX_NESTING > 2) ? $clog2(MAX_NESTING) : 1;

  localparam int ADDR_W  = 32;
  localparam int FRAME_W = 16;
  localparam int RAW_W   = 8;
  localparam int RAW_N   = 1 << RAW_W;

  // Push sizes in bytes
  localparam logic [FRAME_W-1:0] OP_SIZE_16 = 16'd2;
  localparam logic [FRAME_W-1:0] OP_SIZE_32 = 16'd4;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef lvl_t lvl_lut_t [RAW_N];

  // Reduce the nesting byte modulo the depth, worked out at elaboration
  function automatic lvl_lut_t build_level_lut();
    lvl_lut_t lut;
    for (int i = 0; i < RAW_N; i++) begin
      lut[i] = lvl_t'(i % MAX_NESTING);
    end
    return lut;
  endfunction

  localparam lvl_lut_t LEVEL_LUT = build_level_lut();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_BP,
    ST_CUR,
    ST_COPY,
    ST_PUSH_FP,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    OPS_SP_SIZE,
    OPS_CUR_SIZE,
    OPS_SP_FRAME
  } op_sel_t;

  typedef enum logic [1:0] {
    EM_PUSH_BP,
    EM_COPY,
    EM_PUSH_FP,
    EM_FINAL
  } emit_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic    load;
    op_sel_t op_sel;
    logic    sp_we;
    logic    cur_we;
    logic    fp_we;
    logic    emit;
    emit_t   emit_sel;
  } ctrl_t;

  // Offset as seen on the stack: 16-bit stacks use the low half only
  function automatic logic [ADDR_W-1:0] as_offset(input logic [ADDR_W-1:0] r,
                                                  input logic s32);
    return s32 ? r : {16'h0000, r[15:0]};
  endfunction

endpackage

// ----- design/sfe_in_if.sv -----
`timescale 1ns / 1ps

interface sfe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_size;
  logic [7:0]  nesting_raw;
  logic        operand_is_16;
  logic        stack_is_32;
  logic [31:0] base_ptr;
  logic [31:0] stack_ptr;

  modport source (
    output valid, frame_size, nesting_raw, operand_is_16, stack_is_32,
           base_ptr, stack_ptr,
    input  ready
  );
  modport sink (
    input  valid, frame_size, nesting_raw, operand_is_16, stack_is_32,
           base_ptr, stack_ptr,
    output ready
  );
endinterface

// ----- design/sfe_out_if.sv -----
`timescale 1ns / 1ps

interface sfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] dest_offset;
  logic [31:0] source_offset;
  logic [31:0] write_value;
  logic        word_is_32;
  logic [31:0] new_base;
  logic [31:0] new_stack;
  logic        last;

  modport source (
    output valid, kind, dest_offset, source_offset, write_value, word_is_32,
           new_base, new_stack, last,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_offset, source_offset, write_value, word_is_32,
           new_base, new_stack, last,
    output ready
  );
endinterface

// ----- design/stack_frame_enter_sequencer_unit.sv -----
`timescale 1ns / 1ps

// Channel | Dir | Payload                                           | Handshake
// in_ch   | in  | frame_size, nesting_raw, operand/stack size flags,| valid/ready
//         |     | base_ptr, stack_ptr                               |
// out_ch  | out | kind, offsets, write_value, word_is_32,           | valid/ready
//         |     | new_base, new_stack, last                         |
//
// One ENTER with level L (nesting_raw mod MAX_NESTING) gives L+2 results
// (two at level zero). Each copy uses the shared decrement unit first on
// the display pointer (ST_CUR) and then on the stack pointer (ST_COPY).
// The block takes no new request until the final update is registered.
// A stalled output holds its result and pauses the sequence.
// Reset is synchronous, active low, and clears the sequencer and output valid.
module stack_frame_enter_sequencer_unit
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sfe_in_if.sink     in_ch,
  sfe_out_if.source  out_ch
);

  ctrl_t              ctrl;
  logic               out_free;
  logic [ADDR_W-1:0]  step_reg;
  logic [FRAME_W-1:0] step_amt;
  logic [ADDR_W-1:0]  step_res;
  logic [FRAME_W-1:0] size;
  logic [ADDR_W-1:0]  vmask;

  // Request context
  logic [FRAME_W-1:0] frame_r;
  logic               op16_r;
  logic               s32_r;
  logic [ADDR_W-1:0]  base_r;
  logic [ADDR_W-1:0]  sp_r;
  logic [ADDR_W-1:0]  cur_r;
  logic [ADDR_W-1:0]  fp_r;

  // Output register
  logic               ov_r;
  logic [1:0]         kind_r;
  logic [ADDR_W-1:0]  dest_r;
  logic [ADDR_W-1:0]  src_r;
  logic [ADDR_W-1:0]  val_r;
  logic               w32_r;
  logic [ADDR_W-1:0]  nbase_r;
  logic [ADDR_W-1:0]  nstack_r;
  logic               last_r;

  assign out_free = !ov_r || out_ch.ready;
  assign size     = op16_r ? OP_SIZE_16 : OP_SIZE_32;
  assign vmask    = op16_r ? 32'h0000_FFFF : 32'hFFFF_FFFF;

  sfe_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_nesting_raw (in_ch.nesting_raw),
    .out_free       (out_free),
    .in_ready       (in_ch.ready),
    .ctrl           (ctrl)
  );

  // Pick operands for the shared decrement
  always_comb begin
    case (ctrl.op_sel)
      OPS_CUR_SIZE: begin
        step_reg = cur_r;
        step_amt = size;
      end
      OPS_SP_FRAME: begin
        step_reg = sp_r;
        step_amt = frame_r;
      end
      default: begin
        step_reg = sp_r;
        step_amt = size;
      end
    endcase
  end

  sfe_step_unit u_step (
    .reg_val (step_reg),
    .amount  (step_amt),
    .s32     (s32_r),
    .result  (step_res)
  );

  // Capture the request and advance the pointers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      frame_r <= in_ch.frame_size;
      op16_r  <= in_ch.operand_is_16;
      s32_r   <= in_ch.stack_is_32;
      base_r  <= in_ch.base_ptr;
      cur_r   <= in_ch.base_ptr;
      sp_r    <= in_ch.stack_ptr;
    end else begin
      if (ctrl.sp_we)  sp_r  <= step_res;
      if (ctrl.cur_we) cur_r <= step_res;
    end
    if (ctrl.fp_we) fp_r <= as_offset(step_res, s32_r);
  end

  // Output valid: set on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctrl.emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      case (ctrl.emit_sel)
        EM_PUSH_BP: begin
          kind_r   <= KIND_WRITE;
          dest_r   <= as_offset(step_res, s32_r);
          src_r    <= '0;
          val_r    <= base_r & vmask;
          w32_r    <= !op16_r;
          nbase_r  <= '0;
          nstack_r <= '0;
          last_r   <= 1'b0;
        end
        EM_COPY: begin
          kind_r   <= KIND_COPY;
          dest_r   <= as_offset(step_res, s32_r);
          src_r    <= as_offset(cur_r, s32_r);
          val_r    <= '0;
          w32_r    <= !op16_r;
          nbase_r  <= '0;
          nstack_r <= '0;
          last_r   <= 1'b0;
        end
        EM_PUSH_FP: begin
          kind_r   <= KIND_WRITE;
          dest_r   <= as_offset(step_res, s32_r);
          src_r    <= '0;
          val_r    <= fp_r & vmask;
          w32_r    <= !op16_r;
          nbase_r  <= '0;
          nstack_r <= '0;
          last_r   <= 1'b0;
        end
        default: begin
          kind_r   <= KIND_FINAL;
          dest_r   <= '0;
          src_r    <= '0;
          val_r    <= '0;
          w32_r    <= 1'b0;
          nbase_r  <= s32_r ? fp_r : {base_r[ADDR_W-1:16], fp_r[15:0]};
          nstack_r <= step_res;
          last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.dest_offset   = dest_r;
  assign out_ch.source_offset = src_r;
  assign out_ch.write_value   = val_r;
  assign out_ch.word_is_32    = w32_r;
  assign out_ch.new_base      = nbase_r;
  assign out_ch.new_stack     = nstack_r;
  assign out_ch.last          = last_r;

endmodule

// ----- design/sfe_step_unit.sv -----
`timescale 1ns / 1ps

// Shared decrement: lower a register by n, wrapping at 16 bits on a 16-bit
// stack and keeping the upper half there.
module sfe_step_unit
  import sfe_pkg::*;
(
  input  logic [ADDR_W-1:0]  reg_val,
  input  logic [FRAME_W-1:0] amount,
  input  logic               s32,
  output logic [ADDR_W-1:0]  result
);

  logic [ADDR_W-1:0] full_diff;
  logic [15:0]       low_diff;

  assign full_diff = reg_val - {{(ADDR_W-FRAME_W){1'b0}}, amount};
  assign low_diff  = reg_val[15:0] - amount[15:0];
  assign result    = s32 ? full_diff : {reg_val[ADDR_W-1:16], low_diff};

endmodule

// ----- design/sfe_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer: walks one ENTER through its pushes, copies and final update.
module sfe_ctrl
  import sfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [RAW_W-1:0] in_nesting_raw,
  input  logic             out_free,
  output logic             in_ready,
  output ctrl_t            ctrl
);

  state_t state_r, state_nxt;
  lvl_t   cnt_r, cnt_nxt;
  logic   lvl_nz_r, lvl_nz_nxt;
  lvl_t   level_in;

  assign level_in = LEVEL_LUT[in_nesting_raw];
  assign in_ready = (state_r == ST_IDLE);

  // Next state and copy count
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    lvl_nz_nxt = lvl_nz_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt  = ST_PUSH_BP;
          lvl_nz_nxt = (level_in != '0);
          cnt_nxt    = level_in - lvl_t'(1);
        end
      end
      ST_PUSH_BP: begin
        if (out_free) begin
          if (!lvl_nz_r)         state_nxt = ST_FINAL;
          else if (cnt_r != '0)  state_nxt = ST_CUR;
          else                   state_nxt = ST_PUSH_FP;
        end
      end
      ST_CUR: begin
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        if (out_free) begin
          cnt_nxt   = cnt_r - lvl_t'(1);
          state_nxt = (cnt_r == lvl_t'(1)) ? ST_PUSH_FP : ST_CUR;
        end
      end
      ST_PUSH_FP: begin
        if (out_free) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    ctrl          = '0;
    ctrl.op_sel   = OPS_SP_SIZE;
    ctrl.emit_sel = EM_PUSH_BP;
    case (state_r)
      ST_IDLE: begin
        ctrl.load = in_valid;
      end
      ST_PUSH_BP: begin
        ctrl.sp_we    = out_free;
        ctrl.fp_we    = out_free;
        ctrl.emit     = out_free;
        ctrl.emit_sel = EM_PUSH_BP;
      end
      ST_CUR: begin
        ctrl.op_sel = OPS_CUR_SIZE;
        ctrl.cur_we = 1'b1;
      end
      ST_COPY: begin
        ctrl.sp_we    = out_free;
        ctrl.emit     = out_free;
        ctrl.emit_sel = EM_COPY;
      end
      ST_PUSH_FP: begin
        ctrl.sp_we    = out_free;
        ctrl.emit     = out_free;
        ctrl.emit_sel = EM_PUSH_FP;
      end
      ST_FINAL: begin
        ctrl.op_sel   = OPS_SP_FRAME;
        ctrl.emit     = out_free;
        ctrl.emit_sel = EM_FINAL;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      lvl_nz_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      lvl_nz_r <= lvl_nz_nxt;
    end
  end

endmodule

// ----- design/sfe_checker.sv -----
`timescale 1ns / 1ps

module sfe_checker
  import sfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its kind and end marker
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  // The end marker travels with the final update and only with it
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == KIND_FINAL)))
    else $error("end marker and final kind disagree");

  // Busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Reset leaves no result on offer
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind stack_frame_enter_sequencer_unit sfe_checker u_sfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.last)
);
